FILE: src/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the SQL comment stripper.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [9:0] {
      MODE_PLAIN  = 10'b00_0000_0001,
      MODE_DASH   = 10'b00_0000_0010,
      MODE_LINE   = 10'b00_0000_0100,
      MODE_SQ     = 10'b00_0000_1000,
      MODE_SQ_ESC = 10'b00_0001_0000,
      MODE_DQ     = 10'b00_0010_0000,
      MODE_DQ_ESC = 10'b00_0100_0000,
      MODE_SLASH  = 10'b00_1000_0000,
      MODE_BLOCK  = 10'b01_0000_0000,
      MODE_BSTAR  = 10'b10_0000_0000
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_end;
      logic       last;
   } rsp_item_type;

   // up to two results from one input item, first in item0
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } result_pair_type;

endpackage

FILE: src/sql_comment_stripper.sv
// ----------------------------------------------------------------------------
// sql_comment_stripper
// Removes SQL line and block comments from a byte stream.
// ----------------------------------------------------------------------------
// Input channel req_*: one transfer per text byte (req_tuser = 0) or an end
// command (req_tuser = 1, req_tdata ignored). Output channel rsp_*: the kept
// bytes in order; an end command yields a held dash or slash, if any, then an
// end marker with rsp_tuser = 1 and rsp_tdata = 0. rsp_tlast marks the last
// result caused by one input transfer; an absorbed byte yields none.
// A result passes the input register, then scan decode into the result queue.
// Throughput: one input byte per cycle while the queue has room; output
// drains one item per cycle from a four-entry queue while rsp_tready is
// high. An input waits in the input register until the queue has room for
// a two-item pair, so req_tready drops only when the queue holds more than
// two items, i.e. after several two-result bytes or a stalled receiver.
// Reset clears the scan state to plain text and empties the queue and the
// input register. A receiver stall holds rsp_* stable and fills the queue,
// then backs pressure onto req_tready.
// ----------------------------------------------------------------------------
module sql_comment_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tuser,   // [0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] is_end
   output logic       rsp_tlast
);
   import scs_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic            in_cmd_ff;
   logic [7:0]      in_byte_ff;
   logic            accept, advance, room;
   result_pair_type pair;
   rsp_item_type    head;

   assign advance     = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || advance;
   assign accept      = req_tvalid && req_tready;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   scs_scanner u_scanner (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .cmd       (in_cmd_ff),
      .text_byte (in_byte_ff),
      .result    (pair)
   );

   scs_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .pair      (pair),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = head.out_byte;
   assign rsp_tuser = head.is_end;
   assign rsp_tlast = head.last;

endmodule

FILE: src/scs_scanner.sv
// ----------------------------------------------------------------------------
// scs_scanner
// Scan state register and the per-byte decode that produces zero to two
// result items.
// ----------------------------------------------------------------------------
module scs_scanner (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     cmd,
   input  logic [7:0]               text_byte,
   output scs_pkg::result_pair_type result
);
   import scs_pkg::*;

   scan_mode_type mode_ff, mode_in;
   logic [1:0]    n;
   logic [7:0]    b0, b1;
   logic          end0, end1;

   always_comb begin
      mode_in = mode_ff;
      n       = 2'd0;
      b0      = text_byte;
      b1      = text_byte;
      end0    = 1'b0;
      end1    = 1'b0;
      if (cmd) begin
         mode_in = MODE_PLAIN;
         if (mode_ff == MODE_DASH || mode_ff == MODE_SLASH) begin
            n    = 2'd2;
            b0   = (mode_ff == MODE_DASH) ? CH_DASH : CH_SLASH;
            b1   = 8'h00;
            end1 = 1'b1;
         end else begin
            n    = 2'd1;
            b0   = 8'h00;
            end0 = 1'b1;
         end
      end else begin
         case (mode_ff)
            MODE_DASH: begin
               if (text_byte == CH_DASH) begin
                  mode_in = MODE_LINE;
               end else begin
                  mode_in = MODE_PLAIN;
                  n       = 2'd2;
                  b0      = CH_DASH;
               end
            end
            MODE_LINE: begin
               if (text_byte == CH_NL) begin
                  mode_in = MODE_PLAIN;
                  n       = 2'd1;
               end
            end
            MODE_SQ: begin
               n = 2'd1;
               if (text_byte == CH_NL || text_byte == CH_SQUOTE) begin
                  mode_in = MODE_PLAIN;
               end else if (text_byte == CH_BSLASH) begin
                  mode_in = MODE_SQ_ESC;
               end
            end
            MODE_SQ_ESC: begin
               n       = 2'd1;
               mode_in = MODE_SQ;
            end
            MODE_DQ: begin
               n = 2'd1;
               if (text_byte == CH_NL || text_byte == CH_DQUOTE) begin
                  mode_in = MODE_PLAIN;
               end else if (text_byte == CH_BSLASH) begin
                  mode_in = MODE_DQ_ESC;
               end
            end
            MODE_DQ_ESC: begin
               n       = 2'd1;
               mode_in = MODE_DQ;
            end
            MODE_SLASH: begin
               if (text_byte == CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end else begin
                  mode_in = MODE_PLAIN;
                  n       = 2'd2;
                  b0      = CH_SLASH;
               end
            end
            MODE_BLOCK: begin
               if (text_byte == CH_STAR) begin
                  mode_in = MODE_BSTAR;
               end
            end
            MODE_BSTAR: begin
               if (text_byte == CH_STAR) begin
                  mode_in = MODE_BSTAR;
               end else if (text_byte == CH_SLASH) begin
                  mode_in = MODE_PLAIN;
               end else begin
                  mode_in = MODE_BLOCK;
               end
            end
            default: begin
               // plain text, also any stray code
               if (text_byte == CH_DASH) begin
                  mode_in = MODE_DASH;
               end else if (text_byte == CH_SLASH) begin
                  mode_in = MODE_SLASH;
               end else begin
                  n = 2'd1;
                  if (text_byte == CH_SQUOTE) begin
                     mode_in = MODE_SQ;
                  end else if (text_byte == CH_DQUOTE) begin
                     mode_in = MODE_DQ;
                  end else begin
                     mode_in = MODE_PLAIN;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      result.count          = n;
      result.item0.out_byte = b0;
      result.item0.is_end   = end0;
      result.item0.last     = (n == 2'd1);
      result.item1.out_byte = b1;
      result.item1.is_end   = end1;
      result.item1.last     = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
      end else if (step) begin
         mode_ff <= mode_in;
      end
   end

   a_end_to_plain: assert property (@(posedge clock) disable iff (reset)
      step && cmd |=> mode_ff == MODE_PLAIN)
      else $error("end command did not return scanner to plain text");

   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      cmd |-> (n == 2'd1 && end0) || (n == 2'd2 && end1 && !end0))
      else $error("end command without a single trailing end marker");

   a_two_only_from_hold: assert property (@(posedge clock) disable iff (reset)
      n == 2'd2 |-> mode_ff == MODE_DASH || mode_ff == MODE_SLASH)
      else $error("two results outside a held dash or slash");

endmodule

FILE: src/scs_out_queue.sv
// ----------------------------------------------------------------------------
// scs_out_queue
// Small result queue: takes up to two items a cycle, hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module scs_out_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  scs_pkg::result_pair_type pair,
   output logic                     room,
   output logic                     out_valid,
   input  logic                     out_ready,
   output scs_pkg::rsp_item_type    out_item
);
   import scs_pkg::*;

   rsp_item_type        mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [1:0]          push_n;
   logic                pop;

   assign push_n    = push ? pair.count : 2'd0;
   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_item  = mem[rd_ptr_ff];
   // space for a worst-case pair
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push_n) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem[wr_ptr_ff] <= pair.item0;
      end
      if (push_n == 2'd2) begin
         mem[wr_ptr_ff + QPTR_W'(1)] <= pair.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("result queue written without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      QPTR_W'(wr_ptr_ff - rd_ptr_ff) == QPTR_W'(count_ff))
      else $error("result queue pointers disagree with count");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SQL comment stripper.
// Sends a stream of text bytes and end commands. A few short hand-written
// sequences come first, then random SQL-like tokens: plain characters, line
// comments, block comments, strings with escapes, lone dashes and slashes,
// and raw noise. A scan-mode tracker in the bench works out the kept bytes
// for every accepted transfer. The monitor checks each output transfer
// against the oldest kept byte still waiting.
// ----------------------------------------------------------------------------
module tb_top;
   import scs_pkg::*;

   typedef struct packed {
      logic       cmd;
      logic [7:0] text;
   } sql_char_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] text_byte
   logic       req_tuser  = 1'b0;    // [0] cmd
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tuser;            // [0] is_end
   logic       rsp_tlast;

   sql_char_type  sql_text_q [$];
   rsp_item_type  stripped_q [$];
   scan_mode_type strip_mode = MODE_PLAIN;
   int            queued_count   = 0;
   int            error_count    = 0;
   int            send_idle_pct  = 36;
   int            recv_stall_pct = 69;

   sql_comment_stripper uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic rsp_item_type kept(input logic [7:0] c, input logic is_end);
      rsp_item_type r;
      r.out_byte = c;
      r.is_end   = is_end;
      r.last     = 1'b0;
      return r;
   endfunction

   // Tracks the scan mode and queues the bytes that survive one transfer.
   function automatic void strip_predict(input logic cmd, input logic [7:0] c);
      rsp_item_type outs [2];
      int n;
      n = 0;
      if (cmd) begin
         if (strip_mode == MODE_DASH) begin
            outs[n] = kept(CH_DASH, 1'b0);
            n++;
         end else if (strip_mode == MODE_SLASH) begin
            outs[n] = kept(CH_SLASH, 1'b0);
            n++;
         end
         outs[n] = kept(8'h00, 1'b1);
         n++;
         strip_mode = MODE_PLAIN;
      end else begin
         case (strip_mode)
            MODE_DASH, MODE_SLASH: begin
               if (strip_mode == MODE_DASH && c == CH_DASH) begin
                  strip_mode = MODE_LINE;
               end else if (strip_mode == MODE_SLASH && c == CH_STAR) begin
                  strip_mode = MODE_BLOCK;
               end else begin
                  // held byte goes out, current byte is not rescanned
                  outs[0] = kept((strip_mode == MODE_DASH) ? CH_DASH : CH_SLASH, 1'b0);
                  outs[1] = kept(c, 1'b0);
                  n = 2;
                  strip_mode = MODE_PLAIN;
               end
            end
            MODE_LINE: begin
               if (c == CH_NL) begin
                  outs[0] = kept(c, 1'b0);
                  n = 1;
                  strip_mode = MODE_PLAIN;
               end
            end
            MODE_SQ, MODE_DQ: begin
               if (c == CH_NL || c == ((strip_mode == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE))
                  strip_mode = MODE_PLAIN;
               else if (c == CH_BSLASH)
                  strip_mode = (strip_mode == MODE_SQ) ? MODE_SQ_ESC : MODE_DQ_ESC;
               outs[0] = kept(c, 1'b0);
               n = 1;
            end
            MODE_SQ_ESC, MODE_DQ_ESC: begin
               strip_mode = (strip_mode == MODE_SQ_ESC) ? MODE_SQ : MODE_DQ;
               outs[0] = kept(c, 1'b0);
               n = 1;
            end
            MODE_BLOCK: begin
               if (c == CH_STAR) strip_mode = MODE_BSTAR;
            end
            MODE_BSTAR: begin
               if (c == CH_SLASH) strip_mode = MODE_PLAIN;
               else if (c != CH_STAR) strip_mode = MODE_BLOCK;
            end
            default: begin
               if (c == CH_DASH) begin
                  strip_mode = MODE_DASH;
               end else if (c == CH_SLASH) begin
                  strip_mode = MODE_SLASH;
               end else begin
                  if (c == CH_SQUOTE) strip_mode = MODE_SQ;
                  else if (c == CH_DQUOTE) strip_mode = MODE_DQ;
                  else strip_mode = MODE_PLAIN;
                  outs[0] = kept(c, 1'b0);
                  n = 1;
               end
            end
         endcase
      end
      for (int i = 0; i < n; i++) begin
         outs[i].last = (i == n - 1);
         stripped_q.push_back(outs[i]);
      end
   endfunction

   // Driver: holds a transfer until it is taken, then predicts its output.
   always @(posedge clock) begin
      sql_char_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         strip_mode = MODE_PLAIN;
         stripped_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            strip_predict(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (sql_text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               item = sql_text_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= item.cmd;
               req_tdata  <= item.text;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // Monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (stripped_q.size() == 0) begin
            $display("%0t: unexpected output byte=%h end=%b last=%b", $time,
                     rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = stripped_q.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                        rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== want.is_end) begin
               $display("%0t: is_end expected %b actual %b", $time, want.is_end, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   task automatic add_byte(input logic [7:0] c);
      sql_text_q.push_back('{cmd: 1'b0, text: c});
      queued_count++;
   endtask

   task automatic add_end();
      sql_text_q.push_back('{cmd: 1'b1, text: 8'($urandom_range(255))});
      queued_count++;
   endtask

   // Half the time one of the characters the scanner cares about.
   function automatic logic [7:0] pick_char();
      if ($urandom_range(1)) return 8'($urandom_range(255));
      case ($urandom_range(6))
         0: return CH_DASH;
         1: return CH_SLASH;
         2: return CH_STAR;
         3: return CH_NL;
         4: return CH_SQUOTE;
         5: return CH_DQUOTE;
         default: return CH_BSLASH;
      endcase
   endfunction

   task automatic add_random_token();
      int kind;
      int len;
      logic [7:0] quote;
      kind = $urandom_range(99);
      len  = $urandom_range(8);
      if (kind < 30) begin
         add_byte(pick_char());
      end else if (kind < 42) begin
         add_byte(CH_DASH);
         add_byte(CH_DASH);
         repeat (len) add_byte(pick_char());
         if ($urandom_range(9) != 0) add_byte(CH_NL);
      end else if (kind < 54) begin
         add_byte(CH_SLASH);
         add_byte(CH_STAR);
         repeat (len) add_byte(pick_char());
         repeat ($urandom_range(1, 2)) add_byte(CH_STAR);
         if ($urandom_range(9) != 0) add_byte(CH_SLASH);
      end else if (kind < 70) begin
         quote = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
         add_byte(quote);
         repeat (len) begin
            if ($urandom_range(4) == 0) add_byte(CH_BSLASH);
            add_byte(pick_char());
         end
         add_byte($urandom_range(4) == 0 ? CH_NL : quote);
      end else if (kind < 80) begin
         add_byte($urandom_range(1) ? CH_DASH : CH_SLASH);
         if ($urandom_range(5) == 0) add_end();
         else add_byte(pick_char());
      end else if (kind < 83) begin
         add_end();
      end else begin
         add_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic wait_drained();
      while (sql_text_q.size() > 0 || req_tvalid || stripped_q.size() > 0)
         @(negedge clock);
   endtask

   initial begin
      int target;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // zero byte and all-ones byte are ordinary text
      add_byte(8'h00);
      add_byte(8'hFF);
      // dash then slash: both kept, slash not taken as an opener
      add_byte(CH_DASH);
      add_byte(CH_SLASH);
      // line comment, newline kept
      add_byte(CH_DASH);
      add_byte(CH_DASH);
      add_byte("x");
      add_byte(CH_NL);
      // block comment with stray stars, closing pair dropped
      add_byte(CH_SLASH);
      add_byte(CH_STAR);
      add_byte(CH_STAR);
      add_byte("q");
      add_byte(CH_STAR);
      add_byte(CH_SLASH);
      // single-quoted string: escaped quote, dashes, newline closes
      add_byte(CH_SQUOTE);
      add_byte(CH_BSLASH);
      add_byte(CH_SQUOTE);
      add_byte(CH_DASH);
      add_byte(CH_DASH);
      add_byte(CH_NL);
      // double-quoted string with escaped quote
      add_byte(CH_DQUOTE);
      add_byte(CH_BSLASH);
      add_byte(CH_DQUOTE);
      add_byte(CH_DQUOTE);
      // end commands with a held dash, a held slash, nothing held
      add_byte(CH_DASH);
      add_end();
      add_byte(CH_SLASH);
      add_end();
      add_end();

      for (int phase = 0; phase < 3; phase++) begin
         @(negedge clock);
         send_idle_pct  = (phase == 0) ? 36 : (phase == 1) ? 69 : 0;
         recv_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 36 : 0;
         target = queued_count + 540;
         while (queued_count < target) add_random_token();
         // sender holds off until the block has emptied out
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0 && stripped_q.size() == 0) begin
         $display("** sql_comment_stripper: PASSED **");
      end else begin
         $display("** sql_comment_stripper: FAILED **");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("** sql_comment_stripper: FAILED **");
      $finish;
   end

endmodule
